// ===== rtl/mmf_pkg.sv =====
// Shared types and MIDI status constants for the MIDI message framer.
`default_nettype none

package mmf_pkg;

	// Message length field width; covers the largest supported sysex buffer (64).
	localparam int LEN_W = 7;

	localparam logic [7:0] ST_NOTE_OFF  = 8'h80;
	localparam logic [7:0] ST_NOTE_ON   = 8'h90;
	localparam logic [7:0] ST_CTRL_CHG  = 8'hB0;
	localparam logic [7:0] ST_PROG_CHG  = 8'hC0;
	localparam logic [7:0] ST_SYSEX     = 8'hF0;
	localparam logic [7:0] ST_QTR_FRAME = 8'hF1;
	localparam logic [7:0] ST_SONG_POS  = 8'hF2;
	localparam logic [7:0] ST_SONG_SEL  = 8'hF3;
	localparam logic [7:0] ST_EOX       = 8'hF7;
	localparam logic [7:0] ST_CLOCK     = 8'hF8;
	localparam logic [7:0] ST_START     = 8'hFA;
	localparam logic [7:0] ST_STOP      = 8'hFC;

	typedef enum logic [2:0] {
		KIND_CHAN3   = 3'd0,
		KIND_PROGRAM = 3'd1,
		KIND_SYSEX   = 3'd2,
		KIND_SYS2    = 3'd3,
		KIND_SONGPOS = 3'd4,
		KIND_CLOCK   = 3'd5,
		KIND_START   = 3'd6,
		KIND_STOP    = 3'd7
	} kind_t;

	// One complete message waiting in the buffer.
	typedef struct packed {
		logic             bank;
		logic [LEN_W-1:0] len;
		kind_t            kind;
	} desc_t;

endpackage

`default_nettype wire

// ===== rtl/midi_message_framer.sv =====
// MIDI message framer top level: parser front, descriptor queue, buffered emitter.
// A message is emitted after its last byte is accepted, via the read and output registers.
// One byte per cycle in and one out unless stalled; a message holds up to SYSEX_DEPTH bytes.
// Input stalls only while both buffer banks hold messages not yet fully read from the buffer.
// Reset clears all control state; the message buffer is not cleared and needs no clearing pass.
`default_nettype none

module midi_message_framer
	import mmf_pkg::*;
#(
	parameter int SYSEX_DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// byte input
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  in_byte,
	// message output, one transfer per byte
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic [2:0]       message_kind,
	output logic             last_of_message
);

	// Index width into one bank; buffer has two banks so the parser can fill one
	// while the emitter drains the other.
	localparam int IW = $clog2(SYSEX_DEPTH);

	logic        push;
	desc_t       push_desc;
	logic        pop;
	desc_t       head;
	logic        empty;
	logic        full;
	logic        wr_en;
	logic [IW:0] wr_addr;
	logic [7:0]  wr_data;

	// Front: decodes status, collects data bytes, drops strays and overlong sysex.
	mmf_front #(
		.SYSEX_DEPTH (SYSEX_DEPTH),
		.IW          (IW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_byte   (in_byte),
		.in_stall  (in_stall),
		.full      (full),
		.push      (push),
		.push_desc (push_desc),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	// Finished messages wait here; depth matches the bank count.
	mmf_desc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	// Back: reads the buffer in order, tags kind and last byte, output register.
	mmf_back #(
		.IW (IW)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr_en           (wr_en),
		.wr_addr         (wr_addr),
		.wr_data         (wr_data),
		.head            (head),
		.empty           (empty),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_byte        (out_byte),
		.message_kind    (message_kind),
		.last_of_message (last_of_message)
	);

endmodule

`default_nettype wire

// ===== rtl/mmf_front.sv =====
// Byte parser: classifies incoming bytes, fills a buffer bank, posts finished messages.
`default_nettype none

module mmf_front
	import mmf_pkg::*;
#(
	parameter int SYSEX_DEPTH = 64,
	parameter int IW          = 6
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic [7:0]    in_byte,
	output logic               in_stall,
	input  wire logic          full,
	output logic               push,
	output desc_t              push_desc,
	output logic               wr_en,
	output logic [IW:0]        wr_addr,
	output logic [7:0]         wr_data
);

	localparam int CW = $clog2(SYSEX_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_FIXED = 2'd1,
		ST_SX    = 2'd2
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   fill_q;
	logic [1:0]      exp_len_q;
	kind_t           kind_q;
	logic            bank_q;

	logic            accept;
	logic [CW-1:0]   fill_inc;
	logic [3:0]      hi;
	logic            cls_fixed;
	logic            cls_sysex;
	logic            cls_single;
	logic [1:0]      cls_len;
	kind_t           cls_kind;
	logic [IW-1:0]   wr_idx;

	assign in_stall = full;
	assign accept   = in_valid && !full;
	assign fill_inc = fill_q + 1'b1;
	assign hi       = in_byte[7:4];

	// Status decode while no message is open.
	always_comb begin
		cls_fixed  = 1'b0;
		cls_sysex  = 1'b0;
		cls_single = 1'b0;
		cls_len    = 2'd0;
		cls_kind   = KIND_CHAN3;
		if (hi == ST_NOTE_OFF[7:4] || hi == ST_NOTE_ON[7:4] || hi == ST_CTRL_CHG[7:4]) begin
			cls_fixed = 1'b1;
			cls_len   = 2'd3;
			cls_kind  = KIND_CHAN3;
		end else if (hi == ST_PROG_CHG[7:4]) begin
			cls_fixed = 1'b1;
			cls_len   = 2'd2;
			cls_kind  = KIND_PROGRAM;
		end else if (in_byte == ST_SYSEX) begin
			cls_sysex = 1'b1;
			cls_kind  = KIND_SYSEX;
		end else if (in_byte == ST_QTR_FRAME || in_byte == ST_SONG_SEL) begin
			cls_fixed = 1'b1;
			cls_len   = 2'd2;
			cls_kind  = KIND_SYS2;
		end else if (in_byte == ST_SONG_POS) begin
			cls_fixed = 1'b1;
			cls_len   = 2'd3;
			cls_kind  = KIND_SONGPOS;
		end else if (in_byte == ST_CLOCK) begin
			cls_single = 1'b1;
			cls_kind   = KIND_CLOCK;
		end else if (in_byte == ST_START) begin
			cls_single = 1'b1;
			cls_kind   = KIND_START;
		end else if (in_byte == ST_STOP) begin
			cls_single = 1'b1;
			cls_kind   = KIND_STOP;
		end
	end

	always_comb begin
		wr_idx         = fill_q[IW-1:0];
		wr_en          = accept;
		push           = 1'b0;
		push_desc.bank = bank_q;
		push_desc.len  = LEN_W'(fill_inc);
		push_desc.kind = kind_q;
		unique case (state_q)
			ST_FIXED: begin
				push = accept && (fill_inc >= CW'(exp_len_q));
			end
			ST_SX: begin
				push = accept && (in_byte == ST_EOX);
			end
			default: begin
				wr_idx         = '0;
				wr_en          = accept && (cls_fixed || cls_sysex || cls_single);
				push           = accept && cls_single;
				push_desc.len  = LEN_W'(1);
				push_desc.kind = cls_kind;
			end
		endcase
	end

	assign wr_addr = {bank_q, wr_idx};
	assign wr_data = in_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			exp_len_q <= 2'd0;
			kind_q    <= KIND_CHAN3;
			bank_q    <= 1'b0;
		end else if (accept) begin
			unique case (state_q)
				ST_FIXED: begin
					if (push) begin
						state_q <= ST_IDLE;
						fill_q  <= '0;
						bank_q  <= !bank_q;
					end else begin
						fill_q <= fill_inc;
					end
				end
				ST_SX: begin
					if (push) begin
						state_q <= ST_IDLE;
						fill_q  <= '0;
						bank_q  <= !bank_q;
					end else if (fill_inc == CW'(SYSEX_DEPTH)) begin
						// overlong: drop it
						state_q <= ST_IDLE;
						fill_q  <= '0;
					end else begin
						fill_q <= fill_inc;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					fill_q  <= '0;
					if (cls_fixed) begin
						state_q   <= ST_FIXED;
						fill_q    <= CW'(1);
						exp_len_q <= cls_len;
						kind_q    <= cls_kind;
					end else if (cls_sysex) begin
						state_q <= ST_SX;
						fill_q  <= CW'(1);
						kind_q  <= cls_kind;
					end else if (cls_single) begin
						bank_q <= !bank_q;
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/mmf_desc_fifo.sv =====
// Two-entry queue of finished message descriptors between parser and emitter.
`default_nettype none

module mmf_desc_fifo
	import mmf_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire desc_t push_desc,
	input  wire logic  pop,
	output desc_t      head,
	output logic       empty,
	output logic       full
);

	desc_t       ent_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;

	assign head  = ent_q[rd_ptr_q];
	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_desc;
	end

endmodule

`default_nettype wire

// ===== rtl/mmf_back.sv =====
// Emitter: holds the two-bank message buffer and streams finished messages out.
`default_nettype none

module mmf_back
	import mmf_pkg::*;
#(
	parameter int IW = 6
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic [IW:0] wr_addr,
	input  wire logic [7:0]  wr_data,
	input  wire desc_t       head,
	input  wire logic        empty,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic [2:0]       message_kind,
	output logic             last_of_message
);

	localparam int MEM_DEPTH = 2 << IW;

	logic [7:0]     mem [MEM_DEPTH];
	logic [IW-1:0]  idx_q;
	logic           valid_s1;
	logic [7:0]     rdata_s1;
	kind_t          kind_s1;
	logic           last_s1;
	logic           out_valid_q;
	logic [7:0]     out_byte_q;
	kind_t          out_kind_q;
	logic           out_last_q;

	logic           move;
	logic           ce;
	logic           issue;
	logic           last;
	logic [IW:0]    raddr;

	assign move  = !out_valid_q || !out_stall;
	assign ce    = !valid_s1 || move;
	assign issue = ce && !empty;
	assign last  = (LEN_W'(idx_q) + LEN_W'(1)) == head.len;
	assign pop   = issue && last;
	assign raddr = {head.bank, idx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ce)
				valid_s1 <= issue;
			if (issue)
				idx_q <= last ? '0 : idx_q + 1'b1;
			if (move)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (ce) begin
			rdata_s1 <= mem[raddr];
			kind_s1  <= head.kind;
			last_s1  <= last;
		end
		if (move) begin
			out_byte_q <= rdata_s1;
			out_kind_q <= kind_s1;
			out_last_q <= last_s1;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_byte        = out_byte_q;
	assign message_kind    = out_kind_q;
	assign last_of_message = out_last_q;

endmodule

`default_nettype wire
